// ===== rtl/sha_pkg.sv =====
// Shared types and constants for the SHA-256 stream hasher.
// No dependencies; imported by sha_ctrl, sha_dp and sha256_hash_stream.
`default_nettype none

package sha_pkg;

  typedef enum logic [2:0] {
    S_IN,
    S_PAD80,
    S_ZERO,
    S_LEN_LO,
    S_COMP,
    S_FIN,
    S_OUT
  } state_t;

  // Source of the word shifted into the block buffer
  typedef enum logic [1:0] {
    SEL_IN,
    SEL_PAD80,
    SEL_ZERO,
    SEL_LEN_LO
  } word_sel_t;

  typedef struct packed {
    logic      push;
    word_sel_t sel;
    logic      round;
    logic      finish;
    logic      out_next;
    logic      rearm;
  } cmd_t;

  typedef struct packed {
    logic fill_full;   // next push completes the block
    logic fill_14;     // next push lands on the length high word
    logic round_last;
    logic out_last;
  } status_t;

  localparam logic [2:0] FULL_BYTES = 3'd4;

  localparam logic [31:0] PAD_WORD = 32'h8000_0000;

  localparam logic [31:0] H_INIT [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

// ===== rtl/sha256_hash_stream.sv =====
// Top level of the SHA-256 stream hasher.
// Depends on sha_pkg, sha_ctrl and sha_dp.
`default_nettype none

// SHA-256 (FIPS 180-4) over a word stream. Each input item is one big-endian
// 32-bit word; byte_count gives its valid leading bytes and only matters on
// the item flagged last (a short word before that counts as four bytes, a
// count above four counts as four). An empty message is one last item with
// zero bytes. Words are taken one per cycle until a 16-word block is full;
// the block is then compressed by a single round unit, one round per cycle,
// followed by the chaining add; no item is accepted while a block is
// compressed. After the last item the padding word, zero fill and 64-bit
// bit length are shifted in one word per cycle, pausing while a block is
// compressed (the padding spans one or two blocks), and the digest leaves
// as eight items, H0 first, with last_word set on the eighth. Input is
// held off until the digest is fully taken; the hasher then starts a new
// message from the initial hash values. The bit length wraps modulo 2^64.
module sha256_hash_stream
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  byte_count,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic             last_word
);

  cmd_t    cmd;
  status_t status;

  // sequencer: decides what the datapath does each cycle
  sha_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .last       (last),
    .byte_count (byte_count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // buffer, round unit, chaining state, length count, digest select
  sha_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_word   (data_word),
    .byte_count  (byte_count),
    .last        (last),
    .status      (status),
    .digest_word (digest_word),
    .last_word   (last_word)
  );

endmodule

`default_nettype wire

// ===== rtl/sha_ctrl.sv =====
// Sequencer for the SHA-256 stream hasher: input, padding, rounds, digest out.
// Depends on sha_pkg.
`default_nettype none

module sha_ctrl
  import sha_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       last,
  input  wire logic [2:0] byte_count,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire status_t    status,
  output cmd_t            cmd
);

  state_t state, state_next;
  state_t ret, ret_next;
  state_t nat;   // state after a push that does not close a block

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
      ret   <= S_IN;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next   = state;
    ret_next     = ret;
    nat          = state;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd.push     = 1'b0;
    cmd.sel      = SEL_IN;
    cmd.round    = 1'b0;
    cmd.finish   = 1'b0;
    cmd.out_next = 1'b0;
    cmd.rearm    = 1'b0;
    unique case (state)
      S_IN: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.push = 1'b1;
          if (!last) nat = S_IN;
          else if (byte_count >= FULL_BYTES) nat = S_PAD80;
          else nat = S_ZERO;
        end
      end
      S_PAD80: begin
        cmd.push = 1'b1;
        cmd.sel  = SEL_PAD80;
        nat      = S_ZERO;
      end
      S_ZERO: begin
        cmd.push = 1'b1;
        cmd.sel  = SEL_ZERO;
        nat      = status.fill_14 ? S_LEN_LO : S_ZERO;
      end
      S_LEN_LO: begin
        cmd.push = 1'b1;
        cmd.sel  = SEL_LEN_LO;
        nat      = S_OUT;
      end
      S_COMP: begin
        cmd.round = 1'b1;
        if (status.round_last) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = ret;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.out_next = 1'b1;
          if (status.out_last) begin
            cmd.rearm  = 1'b1;
            state_next = S_IN;
          end
        end
      end
      default: state_next = S_IN;
    endcase
    if (cmd.push) begin
      if (status.fill_full) begin
        state_next = S_COMP;
        ret_next   = nat;
      end else begin
        state_next = nat;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sha_dp.sv =====
// Datapath for the SHA-256 stream hasher: block buffer / schedule window,
// round logic, chaining state and length count. Depends on sha_pkg.
`default_nettype none

module sha_dp
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  byte_count,
  input  wire logic        last,
  output status_t          status,
  output logic [31:0]      digest_word,
  output logic             last_word
);

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] hash [0:7];
  logic [31:0] v    [0:7];
  logic [31:0] w    [0:15];   // block buffer, then sliding schedule window
  logic [60:0] msg_bytes;
  logic [3:0]  fill;
  logic [5:0]  rnd;
  logic [2:0]  out_idx;

  logic [31:0] in_word, push_word, new_w;
  logic [2:0]  add_bytes;
  logic [63:0] bit_len;
  logic [31:0] s1e, ch, t1, s0a, maj, t2;

  assign bit_len = {msg_bytes, 3'b000};

  // Input word with padding merged for a short last item
  always_comb begin
    in_word   = data_word;
    add_bytes = FULL_BYTES;
    if (last) begin
      add_bytes = (byte_count >= FULL_BYTES) ? FULL_BYTES : byte_count;
      case (byte_count)
        3'd0:    in_word = PAD_WORD;
        3'd1:    in_word = {data_word[31:24], 24'h80_0000};
        3'd2:    in_word = {data_word[31:16], 16'h8000};
        3'd3:    in_word = {data_word[31:8], 8'h80};
        default: in_word = data_word;
      endcase
    end
  end

  always_comb begin
    unique case (cmd.sel)
      SEL_IN:     push_word = in_word;
      SEL_PAD80:  push_word = PAD_WORD;
      SEL_ZERO:   push_word = (fill == 4'd14) ? bit_len[63:32] : 32'd0;
      SEL_LEN_LO: push_word = bit_len[31:0];
      default:    push_word = 32'd0;
    endcase
  end

  // One compression round
  always_comb begin
    s1e   = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1    = v[7] + s1e + ch + ROUND_K[rnd] + w[0];
    s0a   = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2    = s0a + maj;
    new_w = (ror(w[14], 17) ^ ror(w[14], 19) ^ (w[14] >> 10)) + w[9]
          + (ror(w[1], 7) ^ ror(w[1], 18) ^ (w[1] >> 3)) + w[0];
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= push_word;
      if (fill == 4'd15) begin
        for (int i = 0; i < 8; i++) v[i] <= hash[i];
      end
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= new_w;
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && fill == 4'd15) rnd <= 6'd0;
    else if (cmd.round) rnd <= rnd + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.rearm) begin
      for (int i = 0; i < 8; i++) hash[i] <= H_INIT[i];
      msg_bytes <= 61'd0;
      fill      <= 4'd0;
      out_idx   <= 3'd0;
    end else begin
      if (cmd.push) begin
        fill <= fill + 4'd1;
        if (cmd.sel == SEL_IN) msg_bytes <= msg_bytes + {58'd0, add_bytes};
      end
      if (cmd.finish) begin
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
      end
      if (cmd.out_next) out_idx <= out_idx + 3'd1;
    end
  end

  assign status.fill_full  = (fill == 4'd15);
  assign status.fill_14    = (fill == 4'd14);
  assign status.round_last = (rnd == 6'd63);
  assign status.out_last   = (out_idx == 3'd7);

  assign digest_word = hash[out_idx];
  assign last_word   = (out_idx == 3'd7);

endmodule

`default_nettype wire
